// ----- hdl/wsg_pkg.sv -----
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types and constants of the three-voice wavetable sound generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int VOICE_COUNT_DEF = 3;
  localparam int VOICE_MAX       = 3;
  localparam int WAVE_WORDS      = 256;
  localparam int WADDR_W         = $clog2(WAVE_WORDS);
  localparam int NIB_W           = 4;
  localparam int PHASE_W         = 20;
  localparam int PHASE_IDX_W     = 5;
  localparam int WSEL_W          = 3;
  localparam int LEVEL_W         = 4;

  localparam int SUM_W       = 11;
  localparam int OPA_W       = SUM_W;
  localparam int OPB_W       = 27;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int Q_W         = 17;

  localparam longint MIX_NUM     = 1792;
  localparam longint MIX_DEN     = 45;
  localparam int     RECIP_SHIFT = 20;
  localparam logic [OPB_W-1:0] RECIP_MULT =
    OPB_W'(((64'd1 << RECIP_SHIFT) * MIX_NUM + MIX_DEN - 1) / MIX_DEN);
  localparam logic [Q_W-1:0] SAT_LIMIT = Q_W'(32000);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [3:0] REG_POINTER    = 4'd0;
  localparam logic [3:0] REG_WAVE_DATA  = 4'd1;
  localparam logic [3:0] REG_CONTROL    = 4'd2;
  localparam logic [3:0] REG_ID         = 4'd3;
  localparam logic [3:0] REG_VOICE_BASE = 4'd4;

  localparam logic [1:0] SLOT_STEP_LO    = 2'd0;
  localparam logic [1:0] SLOT_STEP_MID   = 2'd1;
  localparam logic [1:0] SLOT_STEP_HI    = 2'd2;
  localparam logic [1:0] SLOT_LEVEL_WAVE = 2'd3;

  localparam logic       KIND_READ   = 1'b0;
  localparam logic       KIND_SAMPLE = 1'b1;
  localparam logic [7:0] ID_BYTE     = 8'h57;
  localparam logic [7:0] EMPTY_BYTE  = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         read_data;
    logic signed [15:0] sample;
  } rsp_t;

  typedef enum logic {
    MUL_MAC,
    MUL_SCALE
  } mul_op_t;

  typedef struct packed {
    mul_op_t                  op;
    logic signed [OPA_W-1:0]  a;
    logic signed [OPB_W-1:0]  b;
    logic signed [SUM_W-1:0]  acc;
  } mul_req_t;

endpackage

// ----- hdl/wsg_wave_ram.sv -----
// ----------------------------------------------------------------------------
// wsg_wave_ram
// Wave sample store, one nibble per word, registered read. Entries not yet
// written read as zero through per-entry valid flags.
// ----------------------------------------------------------------------------
module wsg_wave_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [wsg_pkg::WADDR_W-1:0] wr_addr,
  input  logic [wsg_pkg::NIB_W-1:0]   wr_data,
  input  logic [wsg_pkg::WADDR_W-1:0] rd_addr,
  output logic [wsg_pkg::NIB_W-1:0]   rd_data
);
  import wsg_pkg::*;

  logic [NIB_W-1:0]      mem [WAVE_WORDS];
  logic [WAVE_WORDS-1:0] written;
  logic [NIB_W-1:0]      mem_q;
  logic                  written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  assign rd_data = written_q ? mem_q : '0;

endmodule

// ----- hdl/wsg_mul_unit.sv -----
// ----------------------------------------------------------------------------
// wsg_mul_unit
// Shared signed multiplier: voice multiply-accumulate or mix scaling by the
// reciprocal constant.
// ----------------------------------------------------------------------------
module wsg_mul_unit (
  input  wsg_pkg::mul_req_t                 req,
  output logic signed [wsg_pkg::PROD_W-1:0] result
);
  import wsg_pkg::*;

  logic signed [PROD_W-1:0] prod;

  always_comb begin
    prod = req.a * req.b;
    unique case (req.op)
      MUL_MAC:   result = prod + PROD_W'(req.acc);
      MUL_SCALE: result = prod;
    endcase
  end

endmodule

// ----- hdl/wavetable_sound_generator.sv -----
// ----------------------------------------------------------------------------
// wavetable_sound_generator
// Wavetable sound generator: register writes, register reads and sample
// ticks; voices are mixed one at a time through a shared multiplier.
//
//   channel   signals                     carries
//   req       req_valid, req_ready, req   func, reg_addr, write_data
//   rsp       rsp_valid, rsp_ready, rsp   result_kind, read_data, sample
//
// A write is done in S_IDLE, a read passes to S_EMIT; a tick loops through
// S_VOICE, with S_MAC per active voice via the wave RAM read port and the
// shared multiplier, then S_SCALE, S_SAT and S_EMIT (directly S_EMIT while
// disabled). req_ready is low while an item is worked; a result waits in the
// rsp register and the next item is taken. Synchronous reset clears the
// control, voice and handshake registers and the wave store flags.
// ----------------------------------------------------------------------------
module wavetable_sound_generator #(
  parameter int VOICE_COUNT = wsg_pkg::VOICE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  wsg_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output wsg_pkg::rsp_t rsp
);
  import wsg_pkg::*;

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOICE,
    S_MAC,
    S_SCALE,
    S_SAT,
    S_EMIT
  } state_t;

  state_t                  state;
  logic [VIDX_W-1:0]       voice;
  logic                    enabled;
  logic [WADDR_W-1:0]      load_pointer;
  logic [PHASE_W-1:0]      step  [VOICE_COUNT];
  logic [LEVEL_W-1:0]      level [VOICE_COUNT];
  logic [WSEL_W-1:0]       wave  [VOICE_COUNT];
  logic [PHASE_W-1:0]      phase [VOICE_COUNT];
  logic signed [SUM_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic                    negative;
  rsp_t                    res;

  logic [3:0]              voff;
  logic [1:0]              vsel;
  logic [1:0]              slot;
  logic                    voice_hit;
  logic [VIDX_W-1:0]       wvoice;
  logic [PHASE_W-1:0]      phase_sum;
  logic                    voice_active;
  logic [WADDR_W-1:0]      rd_addr;
  logic [NIB_W-1:0]        nib;
  logic                    ram_wr;
  logic signed [5:0]       term;
  logic [SUM_W-2:0]        mag;
  mul_req_t                mreq;
  logic signed [PROD_W-1:0] mresult;
  logic [Q_W-1:0]          q;
  logic [Q_W-1:0]          q_sat;
  logic [Q_W-1:0]          q_signed;
  logic                    phase_live;

  assign req_ready = (state == S_IDLE);

  assign voff      = req.reg_addr - REG_VOICE_BASE;
  assign vsel      = voff[3:2];
  assign slot      = voff[1:0];
  assign voice_hit = (req.reg_addr >= REG_VOICE_BASE) && (int'(vsel) < VOICE_COUNT);
  assign wvoice    = VIDX_W'(vsel);

  assign ram_wr = req_valid && req_ready && (req.func == FUNC_WRITE)
                  && (req.reg_addr == REG_WAVE_DATA);

  assign phase_sum    = phase[voice] + step[voice];
  assign voice_active = (level[voice] != '0) && (step[voice] != '0);
  assign rd_addr      = {wave[voice], phase_sum[PHASE_W-1 -: PHASE_IDX_W]};

  wsg_wave_ram u_wave_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ram_wr),
    .wr_addr (load_pointer),
    .wr_data (req.write_data[NIB_W-1:0]),
    .rd_addr (rd_addr),
    .rd_data (nib)
  );

  assign term = $signed({1'b0, nib, 1'b0}) - 6'sd15;
  assign mag  = acc[SUM_W-1] ? (SUM_W-1)'(-acc) : acc[SUM_W-2:0];

  always_comb begin
    if (state == S_SCALE) begin
      mreq.op = MUL_SCALE;
      mreq.a  = $signed({1'b0, mag});
      mreq.b  = $signed(RECIP_MULT);
    end else begin
      mreq.op = MUL_MAC;
      mreq.a  = OPA_W'(term);
      mreq.b  = $signed(OPB_W'(level[voice]));
    end
    mreq.acc = acc;
  end

  wsg_mul_unit u_mul (
    .req    (mreq),
    .result (mresult)
  );

  assign q        = prod[RECIP_SHIFT +: Q_W];
  assign q_sat    = (q > SAT_LIMIT) ? SAT_LIMIT : q;
  assign q_signed = negative ? (Q_W)'(-q_sat) : q_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      voice        <= '0;
      enabled      <= 1'b0;
      load_pointer <= '0;
      acc          <= '0;
      negative     <= 1'b0;
      rsp_valid    <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        step[i]  <= '0;
        level[i] <= '0;
        wave[i]  <= '0;
        phase[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            unique case (req.func)
              FUNC_WRITE: begin
                priority if (req.reg_addr == REG_POINTER) begin
                  load_pointer <= req.write_data;
                end else if (req.reg_addr == REG_WAVE_DATA) begin
                  load_pointer <= load_pointer + 1'b1;
                end else if (req.reg_addr == REG_CONTROL) begin
                  enabled <= req.write_data[0];
                  if (!req.write_data[0]) begin
                    for (int i = 0; i < VOICE_COUNT; i++) begin
                      phase[i] <= '0;
                    end
                  end
                end else if (voice_hit) begin
                  unique case (slot)
                    SLOT_STEP_LO:    step[wvoice][7:0]   <= req.write_data;
                    SLOT_STEP_MID:   step[wvoice][15:8]  <= req.write_data;
                    SLOT_STEP_HI:    step[wvoice][19:16] <= req.write_data[3:0];
                    SLOT_LEVEL_WAVE: begin
                      level[wvoice] <= req.write_data[3:0];
                      wave[wvoice]  <= req.write_data[6:4];
                    end
                  endcase
                end
              end
              FUNC_READ: begin
                res.result_kind <= KIND_READ;
                res.read_data   <= (req.reg_addr == REG_ID) ? ID_BYTE : EMPTY_BYTE;
                res.sample      <= '0;
                state           <= S_EMIT;
              end
              FUNC_TICK: begin
                res.result_kind <= KIND_SAMPLE;
                res.read_data   <= '0;
                res.sample      <= '0;
                acc             <= '0;
                voice           <= '0;
                state           <= enabled ? S_VOICE : S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_VOICE: begin
          if (voice_active) begin
            phase[voice] <= phase_sum;
            state        <= S_MAC;
          end else if (voice == LAST_VOICE) begin
            state <= S_SCALE;
          end else begin
            voice <= voice + 1'b1;
          end
        end
        S_MAC: begin
          acc <= mresult[SUM_W-1:0];
          if (voice == LAST_VOICE) begin
            state <= S_SCALE;
          end else begin
            voice <= voice + 1'b1;
            state <= S_VOICE;
          end
        end
        S_SCALE: begin
          prod     <= mresult;
          negative <= acc[SUM_W-1];
          state    <= S_SAT;
        end
        S_SAT: begin
          res.sample <= $signed(q_signed[15:0]);
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    phase_live = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      phase_live = phase_live | (phase[i] != '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == KIND_SAMPLE) |->
      (rsp.sample <= 16'sd32000 && rsp.sample >= -16'sd32000 && rsp.read_data == 8'h00))
    else $error("sample result out of range");

  a_read_form: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == KIND_READ) |->
      (rsp.sample == 16'sd0 && (rsp.read_data == ID_BYTE || rsp.read_data == EMPTY_BYTE)))
    else $error("malformed read result");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> !phase_live)
    else $error("phase moved while disabled");

  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_VOICE || state == S_MAC) |-> (int'(voice) < VOICE_COUNT))
    else $error("voice counter out of range");
`endif

endmodule

// ----- tb/wavetable_sound_generator_tb.sv -----
// ----------------------------------------------------------------------------
// wavetable_sound_generator_tb
// Self-checking bench for the three-voice wavetable sound generator. Sends
// register writes, register reads and sample ticks over the request channel,
// mirrors the card's wave store, voice registers and phase accumulators in a
// local mixer model, and compares every response beat field by field, with
// random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module wavetable_sound_generator_tb;

  import wsg_pkg::*;

  localparam logic [1:0]  FUNC_IGNORED = 2'd3;
  localparam int          MIX_VOICES   = VOICE_COUNT_DEF;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_CYCLES = 300;
  localparam int          SAT_VALUE    = 32000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  wavetable_sound_generator uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // mixer model state
  logic [NIB_W-1:0]   wave_mem [WAVE_WORDS];
  logic [7:0]         wave_ptr;
  logic               card_on;
  logic [PHASE_W-1:0] step_reg  [MIX_VOICES];
  logic [PHASE_W-1:0] phase_acc [MIX_VOICES];
  logic [LEVEL_W-1:0] level_reg [MIX_VOICES];
  logic [WSEL_W-1:0]  wsel_reg  [MIX_VOICES];

  rsp_t        pending_rsp [$];
  int unsigned sender_gap_max;
  int unsigned receiver_gap_max;
  int unsigned stall_request;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned idle_cycles;
  int unsigned n_writes, n_reads, n_ticks, n_ignored;

  task automatic clear_mixer_model();
    for (int i = 0; i < WAVE_WORDS; i++) wave_mem[i] = '0;
    wave_ptr = '0;
    card_on  = 1'b0;
    for (int v = 0; v < MIX_VOICES; v++) begin
      step_reg[v]  = '0;
      phase_acc[v] = '0;
      level_reg[v] = '0;
      wsel_reg[v]  = '0;
    end
  endtask

  task automatic apply_write(logic [3:0] addr, logic [7:0] data);
    logic [3:0] offs;
    int         v;
    offs = addr - REG_VOICE_BASE;
    v    = int'(offs[3:2]);
    case (addr)
      REG_POINTER: wave_ptr = data;
      REG_WAVE_DATA: begin
        wave_mem[wave_ptr] = data[3:0];
        wave_ptr           = wave_ptr + 8'd1;
      end
      REG_CONTROL: begin
        card_on = data[0];
        if (!card_on) begin
          for (int i = 0; i < MIX_VOICES; i++) phase_acc[i] = '0;
        end
      end
      REG_ID: ;
      default: begin
        if (v < MIX_VOICES) begin
          case (offs[1:0])
            SLOT_STEP_LO:  step_reg[v][7:0]   = data;
            SLOT_STEP_MID: step_reg[v][15:8]  = data;
            SLOT_STEP_HI:  step_reg[v][19:16] = data[3:0];
            SLOT_LEVEL_WAVE: begin
              level_reg[v] = data[3:0];
              wsel_reg[v]  = data[6:4];
            end
          endcase
        end
      end
    endcase
  endtask

  function automatic logic signed [15:0] mix_tick();
    int         mix;
    int         mag;
    int         scaled;
    logic [7:0] idx;
    mix = 0;
    if (!card_on) return '0;
    for (int v = 0; v < MIX_VOICES; v++) begin
      if (level_reg[v] != '0 && step_reg[v] != '0) begin
        phase_acc[v] = phase_acc[v] + step_reg[v];
        idx = {wsel_reg[v], phase_acc[v][PHASE_W-1 -: PHASE_IDX_W]};
        mix += (2 * int'(wave_mem[idx]) - 15) * int'(level_reg[v]);
      end
    end
    mag    = (mix < 0) ? -mix : mix;
    scaled = int'((longint'(mag) * MIX_NUM) / MIX_DEN);
    if (scaled > SAT_VALUE) scaled = SAT_VALUE;
    return 16'((mix < 0) ? -scaled : scaled);
  endfunction

  task automatic predict_beat(req_t beat);
    rsp_t r;
    r = '0;
    case (beat.func)
      FUNC_WRITE: begin
        apply_write(beat.reg_addr, beat.write_data);
        n_writes++;
      end
      FUNC_READ: begin
        r.result_kind = KIND_READ;
        r.read_data   = (beat.reg_addr == REG_ID) ? ID_BYTE : EMPTY_BYTE;
        pending_rsp.push_back(r);
        n_reads++;
      end
      FUNC_TICK: begin
        r.result_kind = KIND_SAMPLE;
        r.sample      = mix_tick();
        pending_rsp.push_back(r);
        n_ticks++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_beat(logic [1:0] f, logic [3:0] addr, logic [7:0] data);
    int unsigned gap;
    req_t        beat;
    beat.func       = f;
    beat.reg_addr   = addr;
    beat.write_data = data;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    do @(posedge clk); while (!req_ready);
    predict_beat(beat);
  endtask

  function automatic logic [3:0] voice_reg(int v, logic [1:0] slot);
    return REG_VOICE_BASE + 4'(4 * v) + 4'(slot);
  endfunction

  // Returns 1 when the beat does real work, 0 when the card ignores it.
  task automatic send_random_beat(output bit counted);
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 40) begin
      send_beat(FUNC_TICK, 4'($urandom), 8'($urandom));
    end else if (pick < 50) begin
      send_beat(FUNC_READ, 4'($urandom), 8'($urandom));
    end else if (pick < 64) begin
      send_beat(FUNC_WRITE, REG_WAVE_DATA, 8'($urandom));
    end else if (pick < 68) begin
      send_beat(FUNC_WRITE, REG_POINTER, 8'($urandom));
    end else if (pick < 86) begin
      send_beat(FUNC_WRITE, 4'($urandom_range(REG_VOICE_BASE, 15)), 8'($urandom));
    end else if (pick < 90) begin
      send_beat(FUNC_WRITE, REG_CONTROL,
                {7'($urandom), 1'($urandom_range(0, 9) != 0)});
    end else if (pick < 95) begin
      send_beat(FUNC_WRITE, REG_ID, 8'($urandom));
      counted = 1'b0;
    end else begin
      send_beat(FUNC_IGNORED, 4'($urandom), 8'($urandom));
      counted = 1'b0;
    end
  endtask

  task automatic run_random(int unsigned beats);
    int unsigned done;
    bit          counted;
    done = 0;
    while (done < beats) begin
      send_random_beat(counted);
      if (counted) done++;
    end
  endtask

  task automatic test_directed();
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
    send_beat(FUNC_READ, REG_ID, 8'h00);
    send_beat(FUNC_READ, REG_POINTER, 8'hFF);
    send_beat(FUNC_READ, 4'hF, 8'h00);
    send_beat(FUNC_IGNORED, 4'hF, 8'hFF);
    send_beat(FUNC_WRITE, REG_ID, 8'hFF);
    send_beat(FUNC_WRITE, REG_POINTER, 8'hFF);
    send_beat(FUNC_WRITE, REG_WAVE_DATA, 8'hFF);
    send_beat(FUNC_WRITE, REG_WAVE_DATA, 8'h00);
    send_beat(FUNC_READ, REG_WAVE_DATA, 8'h00);
    send_beat(FUNC_WRITE, REG_CONTROL, 8'h01);
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
    send_beat(FUNC_WRITE, voice_reg(2, SLOT_STEP_LO), 8'hFF);
    send_beat(FUNC_WRITE, voice_reg(2, SLOT_STEP_MID), 8'hFF);
    send_beat(FUNC_WRITE, voice_reg(2, SLOT_STEP_HI), 8'hFF);
    send_beat(FUNC_WRITE, voice_reg(2, SLOT_LEVEL_WAVE), 8'hFF);
    send_beat(FUNC_WRITE, voice_reg(0, SLOT_LEVEL_WAVE), 8'h3F);
    send_beat(FUNC_TICK, 4'hF, 8'hFF);
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
    send_beat(FUNC_WRITE, voice_reg(1, SLOT_STEP_LO), 8'h01);
    send_beat(FUNC_WRITE, voice_reg(1, SLOT_LEVEL_WAVE), 8'h01);
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
    send_beat(FUNC_WRITE, REG_CONTROL, 8'hFE);
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
    send_beat(FUNC_WRITE, REG_CONTROL, 8'h01);
    send_beat(FUNC_TICK, REG_POINTER, 8'h00);
  endtask

  task automatic test_wave_load();
    send_beat(FUNC_WRITE, REG_POINTER, 8'h00);
    for (int i = 0; i < WAVE_WORDS; i++) begin
      send_beat(FUNC_WRITE, REG_WAVE_DATA, 8'($urandom));
    end
    for (int v = 0; v < MIX_VOICES; v++) begin
      for (int s = 0; s < 4; s++) begin
        send_beat(FUNC_WRITE, voice_reg(v, 2'(s)), 8'($urandom));
      end
    end
    send_beat(FUNC_WRITE, REG_CONTROL, 8'h01);
  endtask

  task automatic test_random_mix();
    int unsigned gap_choice [3];
    gap_choice = '{0, 2, 11};
    for (int seg = 0; seg < 10; seg++) begin
      sender_gap_max   = gap_choice[$urandom_range(0, 2)];
      receiver_gap_max = gap_choice[$urandom_range(0, 2)];
      run_random(100);
    end
    sender_gap_max   = 11;
    receiver_gap_max = 11;
  endtask

  task automatic test_receiver_hold();
    sender_gap_max = 0;
    stall_request  = STALL_CYCLES;
    run_random(40);
    sender_gap_max = 11;
  endtask

  task automatic test_back_to_back();
    sender_gap_max   = 0;
    receiver_gap_max = 0;
    run_random(150);
    sender_gap_max   = 11;
    receiver_gap_max = 11;
  endtask

  task automatic report_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
    if (mismatch_count < 40) begin
      $display("mismatch in %s of result %0d: got %0d, expected %0d",
               field, results_checked, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat kind", 32'(rsp.result_kind), -1);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.result_kind !== want.result_kind)
          report_mismatch("result_kind", 32'(rsp.result_kind), 32'(want.result_kind));
        if (rsp.read_data !== want.read_data)
          report_mismatch("read_data", 32'(rsp.read_data), 32'(want.read_data));
        if (rsp.sample !== want.sample)
          report_mismatch("sample", 32'(rsp.sample), 32'(want.sample));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    rsp_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall         = $urandom_range(0, receiver_gap_max) + stall_request;
      stall_request = 0;
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    rst              <= 1'b1;
    req_valid        <= 1'b0;
    req              <= '0;
    sender_gap_max   = 11;
    receiver_gap_max = 11;
    stall_request    = 0;
    mismatch_count   = 0;
    results_checked  = 0;
    idle_cycles      = 0;
    n_writes         = 0;
    n_reads          = 0;
    n_ticks          = 0;
    n_ignored        = 0;
    clear_mixer_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_wave_load();
    test_random_mix();
    test_receiver_hold();
    test_back_to_back();

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d writes, %0d reads, %0d ticks and %0d ignored beats under random,",
             n_writes, n_reads, n_ticks, n_ignored);
    $display("back-to-back and stalled handshakes; %0d responses compared, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
